/* design/elastic_circle_collision_unit_defines.svh */
// Assertion macros for the elastic circle collision unit.
// Each macro expects clk and rst_n in scope.
`ifndef ELASTIC_CIRCLE_COLLISION_UNIT_DEFINES_SVH
`define ELASTIC_CIRCLE_COLLISION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ECC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecc check failed: same cycle");
// next-cycle implication
`define ECC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecc check failed: next cycle");
`else
`define ECC_ASSERT_NOW(label, ante, cons)
`define ECC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/ecc_pkg.sv */
package ecc_pkg;

    // default widths
    localparam int ECC_VALUE_W = 32;
    localparam int ECC_MASS_W  = 16;

    // operand chunk width of the pipelined multipliers
    localparam int ECC_CHUNK_W = 32;

    typedef enum logic {
        OP_ELASTIC = 1'b0,
        OP_RING    = 1'b1
    } op_t;

endpackage

/* design/ecc_ifs.sv */
// Input word channel: one collision pair per word.
interface ecc_item_if #(
    parameter int VW = ecc_pkg::ECC_VALUE_W,
    parameter int MW = ecc_pkg::ECC_MASS_W
) ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic signed [VW-1:0] first_pos_x;
    logic signed [VW-1:0] first_pos_y;
    logic signed [VW-1:0] second_pos_x;
    logic signed [VW-1:0] second_pos_y;
    logic signed [VW-1:0] first_vel_x;
    logic signed [VW-1:0] first_vel_y;
    logic signed [VW-1:0] second_vel_x;
    logic signed [VW-1:0] second_vel_y;
    logic        [MW-1:0] first_mass;
    logic        [MW-1:0] second_mass;

    modport source (
        output valid, opcode, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
               first_vel_x, first_vel_y, second_vel_x, second_vel_y,
               first_mass, second_mass,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
               first_vel_x, first_vel_y, second_vel_x, second_vel_y,
               first_mass, second_mass,
        output ready
    );
endinterface

// Result word channel.
interface ecc_result_if #(
    parameter int VW = ecc_pkg::ECC_VALUE_W
) ();
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] new_first_vel_x;
    logic signed [VW-1:0] new_first_vel_y;
    logic signed [VW-1:0] new_second_vel_x;
    logic signed [VW-1:0] new_second_vel_y;
    logic                 fault;

    modport source (
        output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
               new_second_vel_y, fault,
        input  ready
    );
    modport sink (
        input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
               new_second_vel_y, fault,
        output ready
    );
endinterface

/* design/elastic_circle_collision_unit.sv */
// Channel  Dir  Payload
// item     in   opcode, two centres, two velocities, two masses
// result   out  four new velocity components, fault
//
// One word is accepted every cycle while the output register is free or being
// emptied; the quotient is formed one bit per stage.
// rst_n clears all valid bits at once; payload registers are not reset.
// A held result stalls the whole pipeline in place, so nothing is dropped
// or repeated; item.ready follows the output register's free state.
`include "elastic_circle_collision_unit_defines.svh"

module elastic_circle_collision_unit #(
    parameter int VALUE_WIDTH = ecc_pkg::ECC_VALUE_W,
    parameter int MASS_WIDTH  = ecc_pkg::ECC_MASS_W
) (
    input  logic          clk,
    input  logic          rst_n,
    ecc_item_if.sink      item,
    ecc_result_if.source  result
);
    import ecc_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int MW    = MASS_WIDTH;
    localparam int DW    = VW + 1;           // center difference
    localparam int DIFFW = VW + DW + 2;      // dot products and their difference
    localparam int MOPW  = MW + 2;           // signed mass operand
    localparam int P2W   = DIFFW + MOPW;
    localparam int KW    = P2W + 1;          // doubled impulse factor
    localparam int DENW  = P2W;
    localparam int NUMW  = KW + DW;
    localparam int XW    = NUMW + 1;         // remainder width
    localparam int QB    = VW + 1;           // quotient bits
    localparam int LAST  = QB + 9;           // last context stage
    localparam int NDIV  = QB + 2;           // divider stage count

    localparam logic signed [VW+2:0] SMAX = {4'b0000, {(VW-1){1'b1}}};
    localparam logic signed [VW+2:0] SMIN = {4'b1111, {(VW-1){1'b0}}};

    typedef struct packed {
        op_t                  op;
        logic                 fault;
        logic signed [VW-1:0] v1x;
        logic signed [VW-1:0] v1y;
        logic signed [VW-1:0] v2x;
        logic signed [VW-1:0] v2y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic        [MW-1:0] m1;
        logic        [MW-1:0] m2;
    } ctx_t;

    logic en;
    logic out_vld_reg;
    ctx_t ctx_next;
    ctx_t ctx_reg [0:LAST];
    logic vld_reg [0:LAST];

    // global advance: the output register is free or being emptied
    assign en         = !out_vld_reg || result.ready;
    assign item.ready = en;

    // stage 0: capture and form center difference
    always_comb
    begin
        ctx_next.op    = op_t'(item.opcode);
        ctx_next.fault = 1'b0;
        ctx_next.v1x   = item.first_vel_x;
        ctx_next.v1y   = item.first_vel_y;
        ctx_next.v2x   = item.second_vel_x;
        ctx_next.v2y   = item.second_vel_y;
        ctx_next.dx    = DW'(item.second_pos_x) - DW'(item.first_pos_x);
        ctx_next.dy    = DW'(item.second_pos_y) - DW'(item.first_pos_y);
        ctx_next.m1    = item.first_mass;
        ctx_next.m2    = item.second_mass;
    end

    // context chain; fault is settled at stage 3
    logic fault_c;
    ctx_t ctx3_next;

    always_comb
    begin
        ctx3_next       = ctx_reg[2];
        ctx3_next.fault = fault_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_next;
            for (int t = 1; t <= LAST; t++)
            begin
                if (t == 3)
                begin
                    ctx_reg[t] <= ctx3_next;
                end
                else
                begin
                    ctx_reg[t] <= ctx_reg[t-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t <= LAST; t++)
            begin
                vld_reg[t] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= item.valid;
            for (int t = 1; t <= LAST; t++)
            begin
                vld_reg[t] <= vld_reg[t-1];
            end
        end
    end

    // stages 1-2: squared distance and velocity projections
    logic signed [2*DW-1:0]  p_xx, p_yy;
    logic signed [VW+DW-1:0] p_1x, p_1y, p_2x, p_2y;

    ecc_mul #(.AW(DW), .BW(DW)) u_mul_xx (.clk, .en, .a(ctx_reg[0].dx),
        .b(ctx_reg[0].dx), .p(p_xx));
    ecc_mul #(.AW(DW), .BW(DW)) u_mul_yy (.clk, .en, .a(ctx_reg[0].dy),
        .b(ctx_reg[0].dy), .p(p_yy));
    ecc_mul #(.AW(VW), .BW(DW)) u_mul_1x (.clk, .en, .a(ctx_reg[0].v1x),
        .b(ctx_reg[0].dx), .p(p_1x));
    ecc_mul #(.AW(VW), .BW(DW)) u_mul_1y (.clk, .en, .a(ctx_reg[0].v1y),
        .b(ctx_reg[0].dy), .p(p_1y));
    ecc_mul #(.AW(VW), .BW(DW)) u_mul_2x (.clk, .en, .a(ctx_reg[0].v2x),
        .b(ctx_reg[0].dx), .p(p_2x));
    ecc_mul #(.AW(VW), .BW(DW)) u_mul_2y (.clk, .en, .a(ctx_reg[0].v2y),
        .b(ctx_reg[0].dy), .p(p_2y));

    // stage 3: dot sums, fault and operand select
    logic signed [DIFFW-1:0] dd_c, s1_c, s2_c, diff_c;
    logic        [MW:0]      mt_c;
    logic signed [DIFFW-1:0] kb_next, kb_reg, dd_reg;
    logic signed [MOPW-1:0]  ma1_next, ma2_next, mden_next;
    logic signed [MOPW-1:0]  ma1_reg, ma2_reg, mden_reg;

    always_comb
    begin
        dd_c    = DIFFW'(p_xx) + DIFFW'(p_yy);
        s1_c    = DIFFW'(p_1x) + DIFFW'(p_1y);
        s2_c    = DIFFW'(p_2x) + DIFFW'(p_2y);
        diff_c  = s2_c - s1_c;
        mt_c    = (MW+1)'(ctx_reg[2].m1) + (MW+1)'(ctx_reg[2].m2);
        fault_c = (dd_c == '0) || (ctx_reg[2].op == OP_ELASTIC && mt_c == '0);
        if (ctx_reg[2].op == OP_RING)
        begin
            // first' = v1 - 2*s1*d/D; second velocity untouched
            kb_next   = s1_c;
            ma1_next  = '1;
            ma2_next  = '0;
            mden_next = MOPW'(1);
        end
        else
        begin
            kb_next   = diff_c;
            ma1_next  = MOPW'(ctx_reg[2].m2);
            ma2_next  = -MOPW'(ctx_reg[2].m1);
            mden_next = MOPW'(mt_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kb_reg   <= kb_next;
            dd_reg   <= dd_c;
            ma1_reg  <= ma1_next;
            ma2_reg  <= ma2_next;
            mden_reg <= mden_next;
        end
    end

    // stages 4-5: impulse factors and denominator
    logic signed [P2W-1:0] pk1, pk2, pden;
    logic signed [KW-1:0]  k1_w, k2_w;
    logic        [DENW-1:0] den6_reg, den7_reg;

    ecc_mul #(.AW(DIFFW), .BW(MOPW)) u_mul_k1 (.clk, .en, .a(kb_reg),
        .b(ma1_reg), .p(pk1));
    ecc_mul #(.AW(DIFFW), .BW(MOPW)) u_mul_k2 (.clk, .en, .a(kb_reg),
        .b(ma2_reg), .p(pk2));
    ecc_mul #(.AW(DIFFW), .BW(MOPW)) u_mul_den (.clk, .en, .a(dd_reg),
        .b(mden_reg), .p(pden));

    assign k1_w = {pk1, 1'b0};
    assign k2_w = {pk2, 1'b0};

    // stages 6-7: numerators, one lane per output component
    logic signed [NUMW-1:0] num_w [4];

    for (genvar l = 0; l < 4; l++)
    begin : g_num
        logic signed [KW-1:0] k_sel;
        logic signed [DW-1:0] d_sel;
        assign k_sel = (l < 2) ? k1_w : k2_w;
        assign d_sel = (l % 2 == 0) ? ctx_reg[5].dx : ctx_reg[5].dy;
        ecc_mul #(.AW(KW), .BW(DW)) u_mul_num (.clk, .en, .a(k_sel), .b(d_sel),
            .p(num_w[l]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den6_reg <= pden[DENW-1:0];
            den7_reg <= den6_reg;
        end
    end

    // divider: index 0 magnitude, 1 range check, 2.. one quotient bit each
    logic [XW-1:0]   rem_reg [0:NDIV-1][4];
    logic [QB-1:0]   quo_reg [0:NDIV-1][4];
    logic            neg_reg [0:NDIV-1][4];
    logic            ovf_reg [0:NDIV-1][4];
    logic [DENW-1:0] den_reg [0:NDIV-1];

    // stage 8: sign and magnitude of each numerator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den7_reg;
            for (int l = 0; l < 4; l++)
            begin
                neg_reg[0][l] <= num_w[l][NUMW-1];
                rem_reg[0][l] <= XW'(num_w[l][NUMW-1] ? NUMW'(-num_w[l])
                                                       : NUMW'(num_w[l]));
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= 1'b0;
            end
        end
    end

    // stage 9: quotient too large for its QB-bit register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[1] <= den_reg[0];
            for (int l = 0; l < 4; l++)
            begin
                neg_reg[1][l] <= neg_reg[0][l];
                rem_reg[1][l] <= rem_reg[0][l];
                quo_reg[1][l] <= '0;
                ovf_reg[1][l] <= rem_reg[0][l] >= (XW'(den_reg[0]) << QB);
            end
        end
    end

    // restoring division, most significant quotient bit first
    for (genvar j = 2; j < NDIV; j++)
    begin : g_div
        localparam int BIT = NDIV - 1 - j;
        logic [XW-1:0] dsh;
        assign dsh = XW'(den_reg[j-1]) << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_reg[j-1];
                for (int l = 0; l < 4; l++)
                begin
                    neg_reg[j][l] <= neg_reg[j-1][l];
                    ovf_reg[j][l] <= ovf_reg[j-1][l];
                    if (rem_reg[j-1][l] >= dsh)
                    begin
                        rem_reg[j][l] <= rem_reg[j-1][l] - dsh;
                        quo_reg[j][l] <= quo_reg[j-1][l] | (QB'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_reg[j-1][l];
                        quo_reg[j][l] <= quo_reg[j-1][l];
                    end
                end
            end
        end
    end

    // output stage: signed delta, add and saturate
    logic signed [VW-1:0] vel_w   [4];
    logic signed [VW-1:0] res_next[4];
    logic signed [VW-1:0] res_reg [4];
    logic                 fault_reg;

    assign vel_w[0] = ctx_reg[LAST].v1x;
    assign vel_w[1] = ctx_reg[LAST].v1y;
    assign vel_w[2] = ctx_reg[LAST].v2x;
    assign vel_w[3] = ctx_reg[LAST].v2y;

    for (genvar l = 0; l < 4; l++)
    begin : g_out
        logic [QB-1:0]        qs;
        logic signed [QB:0]   mag_s;
        logic signed [QB:0]   delta;
        logic signed [VW+2:0] sum;
        assign qs    = ovf_reg[NDIV-1][l] ? {1'b1, {VW{1'b0}}} : quo_reg[NDIV-1][l];
        assign mag_s = $signed({1'b0, qs});
        assign delta = ctx_reg[LAST].fault ? '0
                     : (neg_reg[NDIV-1][l] ? -mag_s : mag_s);
        assign sum   = (VW+3)'(vel_w[l]) + (VW+3)'(delta);
        assign res_next[l] = (sum > SMAX) ? SMAX[VW-1:0]
                           : (sum < SMIN) ? SMIN[VW-1:0] : sum[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= res_next;
            fault_reg <= ctx_reg[LAST].fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[LAST];
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.new_first_vel_x  = res_reg[0];
    assign result.new_first_vel_y  = res_reg[1];
    assign result.new_second_vel_x = res_reg[2];
    assign result.new_second_vel_y = res_reg[3];
    assign result.fault            = fault_reg;

    // a finished word always lands in the output register
    `ECC_ASSERT_NEXT(a_last_to_out, en && vld_reg[LAST], result.valid)
    // a held result freezes the input side
    `ECC_ASSERT_NOW(a_stall_blocks_input, result.valid && !result.ready, !item.ready)
    // ring reflection leaves the second body's quotients at zero
    `ECC_ASSERT_NOW(a_ring_second_zero, vld_reg[LAST] && ctx_reg[LAST].op == OP_RING && !ctx_reg[LAST].fault, quo_reg[NDIV-1][2] == '0 && quo_reg[NDIV-1][3] == '0 && !ovf_reg[NDIV-1][2] && !ovf_reg[NDIV-1][3])

endmodule

/* design/ecc_mul.sv */
// Signed pipelined multiplier.
// Operand a is cut into chunks; each chunk times b is registered, then the
// shifted partial products are summed into the output register.
module ecc_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    import ecc_pkg::*;

    localparam int CW  = ECC_CHUNK_W;
    localparam int NCH = (AW + CW - 1) / CW;
    localparam int PPW = CW + 1 + BW;
    localparam int SW  = NCH * CW + BW + 1;

    logic signed [NCH*CW-1:0] a_ext;
    logic signed [PPW-1:0]    pp_next [NCH];
    logic signed [PPW-1:0]    pp_reg  [NCH];
    logic signed [SW-1:0]     acc;
    logic signed [AW+BW-1:0]  p_next;
    logic signed [AW+BW-1:0]  p_reg;

    assign a_ext = (NCH*CW)'(a);

    // partial products: low chunks unsigned, top chunk carries the sign
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            pp_next[c] = $signed({(c == NCH - 1) ? a_ext[c*CW+CW-1] : 1'b0,
                                  a_ext[c*CW +: CW]}) * b;
        end
    end

    // shifted sum of the partial products
    always_comb
    begin
        acc = '0;
        for (int c = 0; c < NCH; c++)
        begin
            acc = acc + (SW'(pp_reg[c]) <<< (c * CW));
        end
        p_next = acc[AW+BW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= pp_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* tb/sv/elastic_circle_collision_unit_tb.sv */
module elastic_circle_collision_unit_tb;
    import ecc_pkg::*;

    localparam int VW          = ECC_VALUE_W;
    localparam int MW          = ECC_MASS_W;
    localparam int PIPE_DEPTH  = VW + 12;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 400;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        op_t                  opcode;
        logic signed [VW-1:0] first_pos_x;
        logic signed [VW-1:0] first_pos_y;
        logic signed [VW-1:0] second_pos_x;
        logic signed [VW-1:0] second_pos_y;
        logic signed [VW-1:0] first_vel_x;
        logic signed [VW-1:0] first_vel_y;
        logic signed [VW-1:0] second_vel_x;
        logic signed [VW-1:0] second_vel_y;
        logic        [MW-1:0] first_mass;
        logic        [MW-1:0] second_mass;
    } pair_t;

    typedef struct {
        logic signed [VW-1:0] first_vel_x;
        logic signed [VW-1:0] first_vel_y;
        logic signed [VW-1:0] second_vel_x;
        logic signed [VW-1:0] second_vel_y;
        logic                 fault;
    } bounce_t;

    logic clk;
    logic rst_n;

    ecc_item_if   #(.VW(VW), .MW(MW)) item ();
    ecc_result_if #(.VW(VW))          result ();

    elastic_circle_collision_unit #(
        .VALUE_WIDTH(VW),
        .MASS_WIDTH (MW)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item.sink),
        .result(result.source)
    );

    bounce_t pending_bounces[$];
    int      error_count;
    int      pairs_sent;
    int      bounces_seen;
    int      faults_seen;
    int      idle_cycles;
    int      burst_left;
    bit      no_gaps;
    bit      hold_request;
    int      hold_count;
    int      stall_pct;
    int      stall_epoch;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // add a correction to a velocity and clip to the signed value range
    function automatic logic signed [VW-1:0] clip_sum(logic signed [VW-1:0] v, wide_t delta);
        wide_t total;
        wide_t vmax;
        wide_t vmin;
        total = delta;
        total = total + v;
        vmax = (wide_t'(1) <<< (VW - 1)) - 1;
        vmin = -vmax - 1;
        if (total > vmax)
            return vmax[VW-1:0];
        if (total < vmin)
            return vmin[VW-1:0];
        return total[VW-1:0];
    endfunction

    // exact collision response, full-width integer arithmetic
    function automatic bounce_t predict_bounce(pair_t p);
        bounce_t b;
        wide_t dx, dy, dist_sq, s1, s2, v1x, v1y, v2x, v2y;
        wide_t m1, m2, mt, den, diff, k1, k2;
        wide_t d1x, d1y, d2x, d2y;
        v1x = p.first_vel_x;
        v1y = p.first_vel_y;
        v2x = p.second_vel_x;
        v2y = p.second_vel_y;
        dx = p.second_pos_x;
        dx = dx - p.first_pos_x;
        dy = p.second_pos_y;
        dy = dy - p.first_pos_y;
        m1 = '0;
        m1[MW-1:0] = p.first_mass;
        m2 = '0;
        m2[MW-1:0] = p.second_mass;
        dist_sq = dx * dx + dy * dy;
        s1 = v1x * dx + v1y * dy;
        s2 = v2x * dx + v2y * dy;
        d1x = '0;
        d1y = '0;
        d2x = '0;
        d2y = '0;
        b.fault = 1'b0;
        mt = m1 + m2;
        if (dist_sq == 0)
            b.fault = 1'b1;
        else if (p.opcode == OP_ELASTIC)
        begin
            if (mt == 0)
                b.fault = 1'b1;
            else
            begin
                den  = mt * dist_sq;
                diff = s2 - s1;
                k1   = 2 * m2 * diff;
                k2   = -(2 * m1 * diff);
                d1x  = (k1 * dx) / den;
                d1y  = (k1 * dy) / den;
                d2x  = (k2 * dx) / den;
                d2y  = (k2 * dy) / den;
            end
        end
        else
        begin
            k1  = -2 * s1;
            d1x = (k1 * dx) / dist_sq;
            d1y = (k1 * dy) / dist_sq;
        end
        b.first_vel_x  = clip_sum(p.first_vel_x, d1x);
        b.first_vel_y  = clip_sum(p.first_vel_y, d1y);
        b.second_vel_x = clip_sum(p.second_vel_x, d2x);
        b.second_vel_y = clip_sum(p.second_vel_y, d2y);
        return b;
    endfunction

    // record accepted words and check results against expectations
    always @(posedge clk)
    begin
        pair_t   p;
        bounce_t want;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (item.valid && item.ready)
            begin
                p.opcode       = op_t'(item.opcode);
                p.first_pos_x  = item.first_pos_x;
                p.first_pos_y  = item.first_pos_y;
                p.second_pos_x = item.second_pos_x;
                p.second_pos_y = item.second_pos_y;
                p.first_vel_x  = item.first_vel_x;
                p.first_vel_y  = item.first_vel_y;
                p.second_vel_x = item.second_vel_x;
                p.second_vel_y = item.second_vel_y;
                p.first_mass   = item.first_mass;
                p.second_mass  = item.second_mass;
                pending_bounces.push_back(predict_bounce(p));
                idle_cycles = 0;
            end
            if (result.valid && result.ready)
            begin
                idle_cycles = 0;
                bounces_seen = bounces_seen + 1;
                if (result.fault)
                    faults_seen = faults_seen + 1;
                if (pending_bounces.size() == 0)
                begin
                    error_count = error_count + 1;
                    $display("%0t: unexpected result word", $time);
                end
                else
                begin
                    want = pending_bounces.pop_front();
                    if (result.new_first_vel_x !== want.first_vel_x)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: new_first_vel_x expected %0d actual %0d", $time,
                                 want.first_vel_x, result.new_first_vel_x);
                    end
                    if (result.new_first_vel_y !== want.first_vel_y)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: new_first_vel_y expected %0d actual %0d", $time,
                                 want.first_vel_y, result.new_first_vel_y);
                    end
                    if (result.new_second_vel_x !== want.second_vel_x)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: new_second_vel_x expected %0d actual %0d", $time,
                                 want.second_vel_x, result.new_second_vel_x);
                    end
                    if (result.new_second_vel_y !== want.second_vel_y)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: new_second_vel_y expected %0d actual %0d", $time,
                                 want.second_vel_y, result.new_second_vel_y);
                    end
                    if (result.fault !== want.fault)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: fault expected %0b actual %0b", $time,
                                 want.fault, result.fault);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // result side: long hold-off on request, otherwise a shifting stall rate
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready = 1'b0;
        else if (hold_count > 0)
        begin
            result.ready = 1'b0;
            hold_count = hold_count - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_count = LONG_HOLD - 1;
            result.ready = 1'b0;
        end
        else
        begin
            stall_epoch = stall_epoch + 1;
            if (stall_epoch >= 150)
            begin
                stall_epoch = 0;
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            result.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // drive one word, with a random gap between bursts, and wait for acceptance
    task automatic send_pair(pair_t p);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                item.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        item.valid        = 1'b1;
        item.opcode       = p.opcode;
        item.first_pos_x  = p.first_pos_x;
        item.first_pos_y  = p.first_pos_y;
        item.second_pos_x = p.second_pos_x;
        item.second_pos_y = p.second_pos_y;
        item.first_vel_x  = p.first_vel_x;
        item.first_vel_y  = p.first_vel_y;
        item.second_vel_x = p.second_vel_x;
        item.second_vel_y = p.second_vel_y;
        item.first_mass   = p.first_mass;
        item.second_mass  = p.second_mass;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        pairs_sent = pairs_sent + 1;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        item.valid = 1'b0;
        burst_left = 0;
    endtask

    // a value: full range, small magnitude, or an extreme
    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            7: return $signed($urandom_range(0, 64)) - 32;
            8: return {1'b0, {(VW-1){1'b1}}};
            default: return {1'b1, {(VW-1){1'b0}}};
        endcase
    endfunction

    function automatic logic [MW-1:0] pick_mass();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return MW'($urandom_range(1, 16));
            default: return MW'($urandom);
        endcase
    endfunction

    function automatic pair_t random_pair(op_t op);
        pair_t p;
        p.opcode       = op;
        p.first_pos_x  = pick_value();
        p.first_pos_y  = pick_value();
        p.first_vel_x  = pick_value();
        p.first_vel_y  = pick_value();
        p.second_vel_x = pick_value();
        p.second_vel_y = pick_value();
        p.first_mass   = pick_mass();
        p.second_mass  = pick_mass();
        // mostly nearby centres; sometimes coincident or anywhere
        case ($urandom_range(0, 9))
            0:
            begin
                p.second_pos_x = p.first_pos_x;
                p.second_pos_y = p.first_pos_y;
            end
            1, 2, 3:
            begin
                p.second_pos_x = pick_value();
                p.second_pos_y = pick_value();
            end
            default:
            begin
                p.second_pos_x = p.first_pos_x + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                p.second_pos_y = p.first_pos_y + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            end
        endcase
        return p;
    endfunction

    function automatic pair_t base_pair(op_t op);
        pair_t p;
        p.opcode       = op;
        p.first_pos_x  = 0;
        p.first_pos_y  = 0;
        p.second_pos_x = 32'sh0002_0000;
        p.second_pos_y = 0;
        p.first_vel_x  = 32'sh0001_0000;
        p.first_vel_y  = 32'sh0000_8000;
        p.second_vel_x = -32'sh0001_0000;
        p.second_vel_y = 0;
        p.first_mass   = MW'(1);
        p.second_mass  = MW'(1);
        return p;
    endfunction

    // hand-picked cases: faults, masses, extremes, saturation
    task automatic test_directed();
        pair_t p;
        pair_t q;
        op_t   op;
        for (int k = 0; k < 2; k++)
        begin
            op = k ? OP_RING : OP_ELASTIC;
            p = base_pair(op);
            send_pair(p);
            // coincident centres
            q = p;
            q.second_pos_x = q.first_pos_x;
            send_pair(q);
            // zero total mass
            q = p;
            q.first_mass  = 0;
            q.second_mass = 0;
            send_pair(q);
            // one massless body, and very unequal masses
            q = p;
            q.first_mass = 0;
            send_pair(q);
            q = p;
            q.first_mass  = '1;
            q.second_mass = MW'(1);
            send_pair(q);
            q.first_mass  = '1;
            q.second_mass = '1;
            send_pair(q);
            // centres at opposite extremes
            q = p;
            q.first_pos_x  = {1'b1, {(VW-1){1'b0}}};
            q.first_pos_y  = {1'b0, {(VW-1){1'b1}}};
            q.second_pos_x = {1'b0, {(VW-1){1'b1}}};
            q.second_pos_y = {1'b1, {(VW-1){1'b0}}};
            send_pair(q);
            // extreme velocities head on, driving the sums into saturation
            q = p;
            q.first_vel_x  = {1'b0, {(VW-1){1'b1}}};
            q.first_vel_y  = {1'b1, {(VW-1){1'b0}}};
            q.second_vel_x = {1'b1, {(VW-1){1'b0}}};
            q.second_vel_y = {1'b0, {(VW-1){1'b1}}};
            q.second_pos_y = 32'sh0002_0000;
            send_pair(q);
            q.second_mass = '1;
            send_pair(q);
            // all bits set in the first centre and the first mass
            q.first_pos_x = '1;
            q.first_pos_y = '1;
            q.first_mass  = '1;
            send_pair(q);
        end
    endtask

    task automatic test_random_elastic(int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair(($urandom_range(0, 9) < 8) ? OP_ELASTIC : OP_RING));
    endtask

    task automatic test_random_ring(int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair(($urandom_range(0, 9) < 8) ? OP_RING : OP_ELASTIC));
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure(int count);
        no_gaps = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < count; i++)
            send_pair(random_pair(op_t'($urandom_range(0, 1))));
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        item.valid        = 1'b0;
        item.opcode       = OP_ELASTIC;
        item.first_pos_x  = '0;
        item.first_pos_y  = '0;
        item.second_pos_x = '0;
        item.second_pos_y = '0;
        item.first_vel_x  = '0;
        item.first_vel_y  = '0;
        item.second_vel_x = '0;
        item.second_vel_y = '0;
        item.first_mass   = '0;
        item.second_mass  = '0;
        result.ready = 1'b0;
        error_count  = 0;
        pairs_sent   = 0;
        bounces_seen = 0;
        faults_seen  = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        hold_count   = 0;
        stall_pct    = 0;
        stall_epoch  = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_elastic(800);
        test_backpressure(200);
        test_random_ring(680);
        idle_sender();

        while (pending_bounces.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d collision pairs (both opcodes, faults, saturation, long stall);",
                 pairs_sent);
        $display("checked %0d result words, %0d of them flagged as faults.",
                 bounces_seen, faults_seen);
        if (error_count == 0 && pending_bounces.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
